// ===== hdl/sdnc_pkg.sv =====
package sdnc_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int COEF_FRAC_DEF  = 14;
  localparam int MAX_HEIGHT     = 4096;
  localparam int WIN            = 8;
  localparam int STORE_LINES    = 7;
  localparam int MIN_DIM        = 8;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // cos(m*pi/16) in Q30, m = 0..8
  localparam logic [31:0] COS_Q30 [9] = '{
    32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
    32'd596538995, 32'd410903207, 32'd209476638, 32'd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_PASS,
    S_FIN,
    S_OUT
  } sdnc_state_e;

  // scaled dct basis entry for frequency u at position x
  function automatic int basis(int u, int x, int frac);
    int     m;
    bit     neg;
    longint mag;
    neg = 1'b0;
    if (u == 0) begin
      m = 4;
    end else begin
      m = ((2 * x + 1) * u) & 31;
      if (m > 16) m = 32 - m;
      if (m > 8) begin
        neg = 1'b1;
        m = 16 - m;
      end
    end
    mag = (longint'(COS_Q30[m]) + (longint'(1) << (30 - frac))) >>> (31 - frac);
    return neg ? -int'(mag) : int'(mag);
  endfunction

endpackage

// ===== hdl/sdnc_ram.sv =====
module sdnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/sliding_dct_nonzero_count.sv =====
// channel   | direction | handshake                  | payload
// pixel     | in        | pixel_valid_i/pixel_stall_o | pixel_i
// result    | out       | result_valid_o/result_stall_i | nonzero_count_o, window_col_o,
//           |           |                            | window_row_o
// cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// a pixel without a full window goes through the line store read and the column
// transform only; one with a window goes through line store read, column transform,
// 8 steps of the row pass through 64 multipliers, a drain step and the output load.
// the line store is a single 7-byte-wide ram, one read and one write per pixel.
// reset clears counters, column transforms, state, valid flags; not the line store.
// a stalled result holds; new pixels are taken while it waits, until the next must load.
module sliding_dct_nonzero_count #(
  parameter int MAX_WIDTH      = sdnc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = sdnc_pkg::COEF_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pixel_valid_i,
  output logic                             pixel_stall_o,
  input  logic [7:0]                       pixel_i,
  output logic                             result_valid_o,
  input  logic                             result_stall_i,
  output logic [6:0]                       nonzero_count_o,
  output logic [10:0]                      window_col_o,
  output logic [11:0]                      window_row_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sdnc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sdnc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import sdnc_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = COEF_FRAC_BITS + 1;
  localparam int PW  = COEF_FRAC_BITS + 11;
  localparam int PRW = CW + PW;
  localparam int SW  = 2 * COEF_FRAC_BITS + 13;
  localparam int LW  = 8 * STORE_LINES;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (2 * COEF_FRAC_BITS - 1);

  logic signed [CW-1:0] coef [WIN][WIN];

  for (genvar gv = 0; gv < WIN; gv++) begin : g_cv
    for (genvar gx = 0; gx < WIN; gx++) begin : g_cx
      assign coef[gv][gx] = CW'(basis(gv, gx, COEF_FRAC_BITS));
    end
  end

  sdnc_state_e state_q, state_d;

  logic [11:0]   width_q;
  logic [12:0]   height_q;
  logic [AW-1:0] col_q;
  logic [11:0]   row_q;
  logic [AW-1:0] col_lat_q;
  logic [11:0]   row_lat_q;
  logic          emit_q;
  logic [7:0]    pix_q;
  logic [2:0]    step_q;
  logic          prod_vld_q;
  logic [6:0]    cnt_q;

  logic signed [PW-1:0]  p_q    [WIN][WIN];
  logic signed [PRW-1:0] prod_q [WIN][WIN];

  logic          out_vld_q;
  logic [6:0]    out_cnt_q;
  logic [10:0]   out_col_q;
  logic [11:0]   out_row_q;

  logic          accept;
  logic          out_load;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] ram_wdata;
  logic [7:0]    col_pix [WIN];
  logic signed [PW-1:0] newp [WIN];
  logic [3:0]    hits;
  logic [31:0]   w_eff, h_eff;
  logic [10:0]   col_sub;
  logic [11:0]   row_sub;

  assign accept        = pixel_valid_i && !pixel_stall_o;
  assign pixel_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    w_eff = 32'(width_q);
    if (w_eff < 32'(MIN_DIM)) w_eff = 32'(MIN_DIM);
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(height_q);
    if (h_eff < 32'(MIN_DIM)) h_eff = 32'(MIN_DIM);
    if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (32'(col_q) + 32'd1 >= w_eff) begin
        col_q <= '0;
        if (32'(row_q) + 32'd1 >= h_eff) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 12'd1;
        end
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q     <= pixel_i;
      col_lat_q <= col_q;
      row_lat_q <= row_q;
      emit_q    <= (32'(col_q) >= 32'd7) && (32'(row_q) >= 32'd7);
    end
  end

  sdnc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPD),
    .waddr_i (col_lat_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // column assembled from the line store plus the new pixel at the bottom
  always_comb begin
    for (int k = 0; k < STORE_LINES; k++) begin
      col_pix[k] = ram_rdata[8*k +: 8];
    end
    col_pix[WIN-1] = pix_q;
    for (int k = 0; k < STORE_LINES; k++) begin
      ram_wdata[8*k +: 8] = col_pix[k+1];
    end
  end

  // vertical transform of the incoming column
  always_comb begin
    for (int u = 0; u < WIN; u++) begin
      newp[u] = '0;
      for (int y = 0; y < WIN; y++) begin
        newp[u] = newp[u] + PW'(PW'(coef[u][y]) * PW'($signed({1'b0, col_pix[y]})));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < WIN; u++) begin
        for (int x = 0; x < WIN; x++) begin
          p_q[u][x] <= '0;
        end
      end
    end else if (state_q == S_UPD) begin
      for (int u = 0; u < WIN; u++) begin
        for (int x = 0; x < WIN - 1; x++) begin
          p_q[u][x] <= p_q[u][x+1];
        end
        p_q[u][WIN-1] <= newp[u];
      end
    end
  end

  // horizontal pass, one frequency v per step
  always_ff @(posedge clk_i) begin
    for (int u = 0; u < WIN; u++) begin
      for (int x = 0; x < WIN; x++) begin
        prod_q[u][x] <= PRW'(coef[step_q][x]) * PRW'(p_q[u][x]);
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    hits = '0;
    for (int u = 0; u < WIN; u++) begin
      s = '0;
      for (int x = 0; x < WIN; x++) begin
        s = s + SW'(prod_q[u][x]);
      end
      if (s >= HALF || s <= -HALF) hits = hits + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      prod_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      prod_vld_q <= (state_q == S_PASS);
      if (state_q == S_PASS) begin
        step_q <= step_q + 3'd1;
      end
      if (state_q == S_UPD) begin
        cnt_q <= '0;
      end else if (prod_vld_q) begin
        cnt_q <= cnt_q + 7'(hits);
      end
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_vld_q || !result_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   state_d = S_UPD;
      S_UPD:  state_d = emit_q ? S_PASS : S_IDLE;
      S_PASS: if (step_q == 3'd7) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign col_sub = 11'(col_lat_q) - 11'd7;
  assign row_sub = row_lat_q - 12'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!result_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cnt_q <= cnt_q;
      out_col_q <= col_sub;
      out_row_q <= row_sub;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign nonzero_count_o = out_cnt_q;
  assign window_col_o    = out_col_q;
  assign window_row_o    = out_row_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> nonzero_count_o <= 7'd64)
    else $error("count above 64");

  a_prod_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> $past(state_q) == S_PASS)
    else $error("product valid outside pass");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) && !emit_q |=> state_q == S_IDLE)
    else $error("pixel without window did not return to idle");

  a_step_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> step_q == 3'd0)
    else $error("pass step not at zero before pass");

endmodule
